FILE: src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared types and codes of the prefix-sum tree engine
// Widths, request codes, walk selects, result kinds and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = 10;
  localparam int CNT_W  = 11;
  localparam int PTR_W  = 12;
  localparam int VAL_W  = 32;
  localparam int REQ_W  = 3;
  localparam int IDX_W  = 11;
  localparam int LAST_W = 10;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PREFIX = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RSUM   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POINT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LOWER  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UPPER  = 3'd6;

  localparam int WSEL_W = 3;
  localparam logic [WSEL_W-1:0] WSEL_ADD_FIRST = 3'd0;
  localparam logic [WSEL_W-1:0] WSEL_ADD_LAST  = 3'd1;
  localparam logic [WSEL_W-1:0] WSEL_SUM_FIRST = 3'd2;
  localparam logic [WSEL_W-1:0] WSEL_SUM_LAST  = 3'd3;
  localparam logic [WSEL_W-1:0] WSEL_SUB_PRIOR = 3'd4;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] RES_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] RES_SUM   = 3'd1;
  localparam logic [KIND_W-1:0] RES_FOUND = 3'd2;
  localparam logic [KIND_W-1:0] RES_ERR   = 3'd3;
  localparam logic [KIND_W-1:0] RES_ZERO  = 3'd4;

  typedef struct packed {
    logic              in_load;
    logic              clear;
    logic              walk_load;
    logic [WSEL_W-1:0] walk_sel;
    logic              walk_run;
    logic              bnd_issue;
    logic              bnd_eval;
    logic              bnd_skip;
    logic              res_load;
    logic [KIND_W-1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             fok;
    logic             lok;
    logic             pok;
    logic             amt_pos;
    logic             amt_neg;
    logic             clear_last;
    logic             walk_busy;
    logic             bnd_done;
    logic             bnd_p_ok;
    logic             out_busy;
  } st_t;

endpackage

`default_nettype wire

FILE: src/pst_ifs.sv
// ----------------------------------------------------------------------------
// pst_ifs: request and result channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_req_if import pst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [IDX_W-1:0]  first_index;
  logic [LAST_W-1:0]        last_index;
  logic signed [VAL_W-1:0]  amount;

  modport source (output valid, req_type, first_index, last_index, amount, input ready);
  modport sink   (input valid, req_type, first_index, last_index, amount, output ready);
endinterface

interface pst_res_if import pst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sum_value;
  logic [CNT_W-1:0]        found_index;
  logic                    status;

  modport source (output valid, sum_value, found_index, status, input ready);
  modport sink   (input valid, sum_value, found_index, status, output ready);
endinterface

`default_nettype wire

FILE: src/pst_datapath.sv
// ----------------------------------------------------------------------------
// pst_datapath: cell memory, walk and search registers, result register
// Holds the tree cells, the element count, the request operands and the
// accumulators; carries out one command group per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_datapath import pst_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [IDX_W-1:0]  first_index,
  input  logic [LAST_W-1:0]        last_index,
  input  logic signed [VAL_W-1:0]  amount,
  input  logic                     res_ready,
  output logic                     res_valid,
  output logic signed [VAL_W-1:0]  sum_value,
  output logic [CNT_W-1:0]         found_index,
  output logic                     status,
  input  cmd_t                     cmd,
  output st_t                      st
);

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(DEPTH)) r = CNT_W'(DEPTH);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] top_of(input logic [CNT_W-1:0] c);
    logic [PTR_W-1:0] n;
    logic [CNT_W-1:0] t;
    n = {1'b0, c} + PTR_W'(1);
    t = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) t = CNT_W'(1) << i;
    end
    return t;
  endfunction

  logic [VAL_W-1:0]        mem [DEPTH];
  logic [VAL_W-1:0]        rdata;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        top_step;
  logic [ADDR_W-1:0]       clr_addr;
  logic [REQ_W-1:0]        req_r;
  logic [IDX_W-1:0]        first_r;
  logic [LAST_W-1:0]       last_r;
  logic [VAL_W-1:0]        amt_r;
  logic [PTR_W-1:0]        ptr;
  logic                    wup;
  logic                    wneg;
  logic                    pend;
  logic [ADDR_W-1:0]       pend_addr;
  logic [VAL_W-1:0]        acc;
  logic [VAL_W-1:0]        w_r;
  logic [CNT_W-1:0]        x_r;
  logic [CNT_W-1:0]        step_r;
  logic                    out_valid;
  logic [VAL_W-1:0]        out_sum;
  logic [CNT_W-1:0]        out_found;
  logic                    out_status;

  logic                    live;
  logic [PTR_W-1:0]        ptr_next;
  logic [PTR_W-1:0]        p;
  logic                    take;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic [PTR_W-1:0]        first_ext;
  logic [PTR_W-1:0]        rd_ptr;

  assign first_ext = {first_r[IDX_W-1], first_r};
  assign live      = (ptr != '0) && (!wup || (ptr <= {1'b0, count}));
  assign ptr_next  = wup ? (ptr + (ptr & (~ptr + PTR_W'(1)))) : (ptr & (ptr - PTR_W'(1)));
  assign p         = {1'b0, x_r} + {1'b0, step_r};
  assign take      = (req_r == REQ_UPPER) ? ($signed(rdata) <= $signed(w_r))
                                          : ($signed(rdata) <  $signed(w_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.walk_run && pend && wup) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = rdata + (wneg ? (~amt_r + VAL_W'(1)) : amt_r);
    end
  end

  assign rd_ptr  = cmd.bnd_issue ? (p - PTR_W'(1)) : (ptr - PTR_W'(1));
  assign rd_addr = rd_ptr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CNT_W'(DEPTH);
      top_step <= top_of(CNT_W'(DEPTH));
      clr_addr <= '0;
    end else if (cfg_we) begin
      count    <= clamp_count(cfg_wdata);
      top_step <= top_of(clamp_count(cfg_wdata));
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_r   <= req_type;
      first_r <= first_index;
      last_r  <= last_index;
      amt_r   <= amount;
      acc     <= '0;
      w_r     <= amount;
      x_r     <= '0;
      step_r  <= top_step;
    end else begin
      if (cmd.walk_run && pend && !wup) begin
        acc <= wneg ? (acc - rdata) : (acc + rdata);
      end
      if (cmd.bnd_eval) begin
        if (take) begin
          w_r <= w_r - rdata;
          x_r <= p[CNT_W-1:0];
        end
        step_r <= step_r >> 1;
      end else if (cmd.bnd_skip) begin
        step_r <= step_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.walk_load) begin
      pend <= 1'b0;
    end else if (cmd.walk_run) begin
      pend <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_load) begin
      case (cmd.walk_sel)
        WSEL_ADD_FIRST: begin
          ptr <= first_ext + PTR_W'(1); wup <= 1'b1; wneg <= 1'b0;
        end
        WSEL_ADD_LAST: begin
          ptr <= {2'b00, last_r} + PTR_W'(2); wup <= 1'b1; wneg <= 1'b1;
        end
        WSEL_SUM_FIRST: begin
          ptr <= first_ext + PTR_W'(1); wup <= 1'b0; wneg <= 1'b0;
        end
        WSEL_SUM_LAST: begin
          ptr <= {2'b00, last_r} + PTR_W'(1); wup <= 1'b0; wneg <= 1'b0;
        end
        default: begin
          ptr <= first_ext; wup <= 1'b0; wneg <= 1'b1;
        end
      endcase
    end else if (cmd.walk_run && live) begin
      ptr       <= ptr_next;
      pend_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_sum    <= (cmd.res_kind == RES_SUM) ? acc : '0;
      out_found  <= (cmd.res_kind == RES_FOUND) ? x_r : '0;
      out_status <= (cmd.res_kind == RES_ERR);
    end
  end

  assign res_valid   = out_valid;
  assign sum_value   = out_sum;
  assign found_index = out_found;
  assign status      = out_status;

  assign st.req_type   = req_r;
  assign st.fok        = !first_r[IDX_W-1] && (first_r < count);
  assign st.lok        = {1'b0, last_r} < count;
  assign st.pok        = st.fok || (first_r == '1);
  assign st.amt_neg    = amt_r[VAL_W-1];
  assign st.amt_pos    = !amt_r[VAL_W-1] && (amt_r != '0);
  assign st.clear_last = (clr_addr == '1);
  assign st.walk_busy  = live || pend;
  assign st.bnd_done   = (step_r == '0);
  assign st.bnd_p_ok   = (p <= {1'b0, count});
  assign st.out_busy   = out_valid && !res_ready;

endmodule

`default_nettype wire

FILE: src/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl: request sequencer
// Clearing pass, request decode, tree walks, bound search steps and result
// hand-off, issued to the datapath as one command group per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl import pst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic req_valid,
  output logic req_ready,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_BRD    = 3'd4;
  localparam logic [2:0] S_BEX    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]        state, state_next;
  logic              second, second_next;
  logic [WSEL_W-1:0] sel2, sel2_next;
  logic [KIND_W-1:0] kind, kind_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    second_next = second;
    sel2_next   = sel2;
    kind_next   = kind;
    cmd         = '0;
    cmd.res_kind = kind;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        second_next = 1'b0;
        kind_next   = RES_NONE;
        state_next  = S_WALK;
        unique case (st.req_type)
          REQ_ADD: begin
            if (st.fok) begin
              cmd.walk_load = 1'b1;
              cmd.walk_sel  = WSEL_ADD_FIRST;
            end else begin
              kind_next  = RES_ERR;
              state_next = S_FINISH;
            end
          end
          REQ_RADD: begin
            if (st.fok && st.lok) begin
              cmd.walk_load = 1'b1;
              cmd.walk_sel  = WSEL_ADD_FIRST;
              second_next   = 1'b1;
              sel2_next     = WSEL_ADD_LAST;
            end else begin
              kind_next  = RES_ERR;
              state_next = S_FINISH;
            end
          end
          REQ_PREFIX: begin
            if (st.pok) begin
              cmd.walk_load = 1'b1;
              cmd.walk_sel  = WSEL_SUM_FIRST;
              kind_next     = RES_SUM;
            end else begin
              kind_next  = RES_ERR;
              state_next = S_FINISH;
            end
          end
          REQ_RSUM: begin
            if (st.fok && st.lok) begin
              cmd.walk_load = 1'b1;
              cmd.walk_sel  = WSEL_SUM_LAST;
              second_next   = 1'b1;
              sel2_next     = WSEL_SUB_PRIOR;
              kind_next     = RES_SUM;
            end else begin
              kind_next  = RES_ERR;
              state_next = S_FINISH;
            end
          end
          REQ_POINT: begin
            if (st.fok) begin
              cmd.walk_load = 1'b1;
              cmd.walk_sel  = WSEL_SUM_FIRST;
              second_next   = 1'b1;
              sel2_next     = WSEL_SUB_PRIOR;
              kind_next     = RES_SUM;
            end else begin
              kind_next  = RES_ERR;
              state_next = S_FINISH;
            end
          end
          REQ_LOWER: begin
            if (st.amt_pos) begin
              kind_next  = RES_FOUND;
              state_next = S_BRD;
            end else begin
              kind_next  = RES_ZERO;
              state_next = S_FINISH;
            end
          end
          REQ_UPPER: begin
            if (!st.amt_neg) begin
              kind_next  = RES_FOUND;
              state_next = S_BRD;
            end else begin
              kind_next  = RES_ZERO;
              state_next = S_FINISH;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (st.walk_busy) begin
          cmd.walk_run = 1'b1;
        end else if (second) begin
          cmd.walk_load = 1'b1;
          cmd.walk_sel  = sel2;
          second_next   = 1'b0;
        end else if (kind == RES_NONE) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_BRD: begin
        if (st.bnd_done) begin
          state_next = S_FINISH;
        end else if (st.bnd_p_ok) begin
          cmd.bnd_issue = 1'b1;
          state_next    = S_BEX;
        end else begin
          cmd.bnd_skip = 1'b1;
        end
      end
      S_BEX: begin
        cmd.bnd_eval = 1'b1;
        state_next   = S_BRD;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    if (cfg_we) begin
      state_next = S_CLEAR;
      cmd.clear  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
      sel2   <= WSEL_ADD_FIRST;
      kind   <= RES_NONE;
    end else begin
      state  <= state_next;
      second <= second_next;
      sel2   <= sel2_next;
      kind   <= kind_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/prefix_sum_tree_engine.sv
// ----------------------------------------------------------------------------
// prefix_sum_tree_engine: binary indexed tree of signed partial sums
// After reset, and after every write of the element count, the 1024-cell
// memory is swept to zero, and no request is taken during the sweep. A
// request is accepted and decoded, then walks the tree one cell per cycle,
// drains the last access and leaves the walk; requests that answer then load
// the result. A point add visits at most 11 cells and a prefix sum at most 10.
// Range adds, range sums and point values make two walks, one after the
// other. Bound searches spend a read state and an evaluate state on each
// halving step that lands inside the count and only the read state on each
// that does not. A bad index or a bound search settled by its threshold alone
// goes from decode straight to the result; an undefined request code is
// dropped without a result. The walks go one cell at a time because the cell
// memory has a single read port. A finished result sits in an output register
// while the next request is taken; a request that ends while that result is
// still unread holds until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_sum_tree_engine import pst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  pst_req_if.sink          req,
  pst_res_if.source        res
);

  cmd_t cmd;
  st_t  st;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_type    (req.req_type),
    .first_index (req.first_index),
    .last_index  (req.last_index),
    .amount      (req.amount),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .sum_value   (res.sum_value),
    .found_index (res.found_index),
    .status      (res.status),
    .cmd         (cmd),
    .st          (st)
  );

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !st.out_busy)
    else $error("pending result overwritten");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status) |-> (res.sum_value == '0 && res.found_index == '0))
    else $error("error result carries data");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.walk_run && !cmd.in_load)
    else $error("clearing pass overlaps a request");

endmodule

`default_nettype wire
